/* design/iap_pkg.sv */
// Shared constants and types for the image axis projection core.
// Depends on nothing; the core refers to it by scoped names.
`timescale 1ns / 1ps

package iap_pkg;

    // Frame geometry limits and pixel depth
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 8;

    // Field widths of the ports
    localparam int PIXEL_W   = 8;
    localparam int SIZE_W    = 11;
    localparam int POS_W     = 10;
    localparam int TOTAL_W   = 18;
    localparam int CFG_IDX_W = 2;

    // Internal widths derived from the limits
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMP_W = SIZE_W + 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [SIZE_W-1:0]    SIZE_RESET       = SIZE_W'(1024);

    // Result axis codes
    localparam logic AXIS_ROW    = 1'b0;
    localparam logic AXIS_COLUMN = 1'b1;

    // Output queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic               axis;
        logic [POS_W-1:0]   position;
        logic [TOTAL_W-1:0] total;
        logic               last_of_item;
    } result_t;

    // Saturating add of a pixel into an 18-bit sum
    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
        end
    endfunction

    // Map a register value into 1..max
    function automatic logic [CMP_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [CMP_W-1:0] max);
        logic [CMP_W-1:0] ve;
        begin
            ve = CMP_W'(v);
            if (ve == '0)
                clamp_size = CMP_W'(1);
            else if (ve > max)
                clamp_size = max;
            else
                clamp_size = ve;
        end
    endfunction

endpackage

/* design/image_axis_projection_core.sv */
// Image axis projection core: per-row and per-column pixel sums of a raster stream.
// Uses iap_pkg for widths, register codes, the result type and saturating add.
// A pixel's results pass the read-modify-write stage, then the output queue. One pixel per
// cycle while the queue has room; the column store is read on transfer and written back as
// stage 1 advances, with forwarding; two results drain one per cycle while out_ready holds.
// Reset clears position, row sum, queue and sets both sizes to 1024; the store needs no clear.
`timescale 1ns / 1ps

module image_axis_projection_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // pixel input
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [iap_pkg::PIXEL_W-1:0]         pixel,
    // result output
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                axis,
    output logic [iap_pkg::POS_W-1:0]           position,
    output logic [iap_pkg::TOTAL_W-1:0]         total,
    output logic                                last_of_item,
    // configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iap_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [iap_pkg::SIZE_W-1:0]          cfg_data
);

    localparam int COL_W   = iap_pkg::COL_W;
    localparam int ROW_W   = iap_pkg::ROW_W;
    localparam int CMP_W   = iap_pkg::CMP_W;
    localparam int TOTAL_W = iap_pkg::TOTAL_W;
    localparam int QPTR_W  = iap_pkg::QPTR_W;
    localparam int QCNT_W  = iap_pkg::QCNT_W;

    // configuration
    logic [iap_pkg::SIZE_W-1:0] width_cfg_reg;
    logic [iap_pkg::SIZE_W-1:0] height_cfg_reg;

    // position tracking and row sum
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [TOTAL_W-1:0] acc_reg, acc_next;

    // read-modify-write stage
    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [TOTAL_W-1:0] s1_pix_reg;
    logic [TOTAL_W-1:0] s1_rowsum_reg;
    logic               s1_last_row_reg;
    logic               s1_row_end_reg;
    logic               fwd_hit_reg;
    logic [TOTAL_W-1:0] fwd_data_reg;
    logic [TOTAL_W-1:0] rd_data_reg;

    logic [TOTAL_W-1:0] column_store [iap_pkg::MAX_WIDTH];

    // output queue
    iap_pkg::result_t   queue_reg [iap_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    logic               in_xfer;
    logic               pop;
    logic               s1_advance;
    logic [QCNT_W-1:0]  count_after_pop;
    logic [CMP_W-1:0]   w_eff, h_eff;
    logic               last_row, row_end;
    logic [TOTAL_W-1:0] pix_ext;
    logic [TOTAL_W-1:0] acc_sum;
    logic [TOTAL_W-1:0] col_base, colsum;
    iap_pkg::result_t   res_first, res_second;
    logic [1:0]         res_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= iap_pkg::SIZE_RESET;
            height_cfg_reg <= iap_pkg::SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                iap_pkg::REG_FRAME_WIDTH:  width_cfg_reg  <= cfg_data;
                iap_pkg::REG_FRAME_HEIGHT: height_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    assign pop             = out_valid && out_ready;
    assign count_after_pop = count_reg - QCNT_W'(pop);
    assign s1_advance      = s1_valid_reg && (count_after_pop <= QCNT_W'(2));
    assign in_ready        = !s1_valid_reg || s1_advance;
    assign in_xfer         = in_valid && in_ready;

    // position and row sum, updated at transfer
    assign w_eff    = iap_pkg::clamp_size(width_cfg_reg, CMP_W'(iap_pkg::MAX_WIDTH));
    assign h_eff    = iap_pkg::clamp_size(height_cfg_reg, CMP_W'(iap_pkg::MAX_HEIGHT));
    assign row_end  = (CMP_W'(col_reg) + CMP_W'(1)) >= w_eff;
    assign last_row = (CMP_W'(row_reg) + CMP_W'(1)) >= h_eff;
    assign pix_ext  = TOTAL_W'(pixel[iap_pkg::PIXEL_BITS-1:0]);
    assign acc_sum  = iap_pkg::sat_add(acc_reg, pix_ext);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        acc_next = acc_reg;
        if (in_xfer)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
                acc_next = '0;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
                acc_next = acc_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            acc_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            acc_reg <= acc_next;
            if (in_xfer)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;
        end
    end

    // stage payload; forward the write leaving stage 1 at the same edge
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_pix_reg      <= pix_ext;
            s1_rowsum_reg   <= acc_sum;
            s1_last_row_reg <= last_row;
            s1_row_end_reg  <= row_end;
            fwd_hit_reg     <= s1_advance && (s1_col_reg == col_reg);
            fwd_data_reg    <= colsum;
        end
    end

    // column store: read on transfer, write back when stage 1 advances
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            rd_data_reg <= column_store[col_reg];
        if (s1_advance)
            column_store[s1_col_reg] <= colsum;
    end

    assign col_base = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign colsum   = (s1_row_reg == '0) ? s1_pix_reg
                                         : iap_pkg::sat_add(col_base, s1_pix_reg);

    // column result goes ahead of the row result
    always_comb
    begin
        iap_pkg::result_t col_res;
        iap_pkg::result_t row_res;
        col_res.axis         = iap_pkg::AXIS_COLUMN;
        col_res.position     = iap_pkg::POS_W'(s1_col_reg);
        col_res.total        = colsum;
        col_res.last_of_item = !s1_row_end_reg;
        row_res.axis         = iap_pkg::AXIS_ROW;
        row_res.position     = iap_pkg::POS_W'(s1_row_reg);
        row_res.total        = s1_rowsum_reg;
        row_res.last_of_item = 1'b1;
        res_first  = s1_last_row_reg ? col_res : row_res;
        res_second = row_res;
        res_count  = 2'(s1_last_row_reg) + 2'(s1_row_end_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            if (res_count != 2'd0)
                queue_reg[wr_ptr_reg] <= res_first;
            if (res_count == 2'd2)
                queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (s1_advance)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(res_count);
                count_reg  <= count_after_pop + QCNT_W'(res_count);
            end
            else
                count_reg <= count_after_pop;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

    assign out_valid    = (count_reg != '0);
    assign axis         = queue_reg[rd_ptr_reg].axis;
    assign position     = queue_reg[rd_ptr_reg].position;
    assign total        = queue_reg[rd_ptr_reg].total;
    assign last_of_item = queue_reg[rd_ptr_reg].last_of_item;

    // queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(iap_pkg::QUEUE_DEPTH))
        else $error("output queue overflow");

    // a stalled stage keeps its column
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("stage 1 lost its item while stalled");

    // the partner of a non-final result is already queued
    a_pair_queued: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !last_of_item |=> out_valid)
        else $error("second result of a pixel missing");

    // a forwarded value only comes from a write to the same column
    a_fwd_same_col: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && s1_advance && (s1_col_reg != col_reg) |=> !fwd_hit_reg)
        else $error("forwarding across different columns");

endmodule
